@@ rtl/windowed_median_offset_monitor_macros.svh @@
// Assertion helpers used by the median monitor datapath.
// All checks sample on clk_i and are off while rst_ni is low.
`ifndef WINDOWED_MEDIAN_OFFSET_MONITOR_MACROS_SVH
`define WINDOWED_MEDIAN_OFFSET_MONITOR_MACROS_SVH

`ifndef SYNTHESIS

`define WMOM_ASSERT_HOLDS(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error("wmom: invariant violated");

`define WMOM_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("wmom: same-cycle implication violated");

`define WMOM_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("wmom: next-cycle implication violated");

`else

`define WMOM_ASSERT_HOLDS(lbl, cond)
`define WMOM_ASSERT_IMP(lbl, ante, cons)
`define WMOM_ASSERT_NXT(lbl, ante, cons)

`endif

`endif

@@ rtl/wmom_pkg.sv @@
package wmom_pkg;

  localparam int WINDOW      = 64;
  localparam int SLOT_W      = $clog2(WINDOW);
  localparam int CNT_W       = $clog2(WINDOW + 1);
  localparam int DATA_W      = 64;
  localparam int THR_W       = 32;
  localparam int CNT_OUT_W   = 7;
  localparam int MIN_SAMPLES = 5;
  localparam logic [THR_W-1:0] THR_RESET = THR_W'(600);

  // one step of the merge pass over the sorted list
  typedef enum logic [1:0] {
    OP_NONE   = 2'd0,
    OP_DROP   = 2'd1,
    OP_INSERT = 2'd2,
    OP_COPY   = 2'd3
  } merge_op_e;

  typedef struct packed {
    logic      start;
    merge_op_e op;
    logic      finish;
    logic      calc;
    logic      load;
  } dp_cmd_t;

  typedef struct packed {
    logic exhausted;
    logic cur_is_rm;
    logic v_before;
    logic ins_done;
  } dp_status_t;

endpackage

@@ rtl/windowed_median_offset_monitor.sv @@
// Channel  Dir  Fields (low bit first)
// s_*      in   offset_sample[63:0]
// m_*      out  median_offset[63:0], sample_count[70:64], out_of_sync[71]
// cfg_*    in   threshold[31:0], written when cfg_we_i is high
//
// Each item runs a merge pass over the sorted list, one entry per cycle, across
// the n samples held before the item (n at most 64); ST_ABS and ST_OUT then
// fill the result register. A new sample that sorts last is written at the end.
// Reset clears the counts and threshold (600); sample stores need no clear.
// A result waits in the output register while the next item is accepted; the
// next load stalls until that result is taken.
module windowed_median_offset_monitor (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_tvalid_i,
  output logic                            s_tready_o,
  input  logic [wmom_pkg::DATA_W-1:0]     s_tdata_i,   // offset_sample
  output logic                            m_tvalid_o,
  input  logic                            m_tready_i,
  output logic [71:0]                     m_tdata_o,   // median, count, out_of_sync
  input  logic                            cfg_we_i,
  input  logic [wmom_pkg::THR_W-1:0]      cfg_wdata_i
);
  import wmom_pkg::*;

  dp_cmd_t              cmd;
  dp_status_t           status;
  logic [DATA_W-1:0]    median;
  logic [CNT_OUT_W-1:0] count;
  logic                 oos;

  wmom_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_tvalid_i),
    .s_tready_o (s_tready_o),
    .m_tvalid_o (m_tvalid_o),
    .m_tready_i (m_tready_i),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  wmom_datapath u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (status),
    .sample_i      (s_tdata_i),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .median_o      (median),
    .count_o       (count),
    .out_of_sync_o (oos)
  );

  assign m_tdata_o = {oos, count, median};

endmodule

@@ rtl/wmom_datapath.sv @@
module wmom_datapath (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  wmom_pkg::dp_cmd_t                 cmd_i,
  output wmom_pkg::dp_status_t              status_o,
  input  logic [wmom_pkg::DATA_W-1:0]       sample_i,
  input  logic                              cfg_we_i,
  input  logic [wmom_pkg::THR_W-1:0]        cfg_wdata_i,
  output logic [wmom_pkg::DATA_W-1:0]       median_o,
  output logic [wmom_pkg::CNT_OUT_W-1:0]    count_o,
  output logic                              out_of_sync_o
);
  import wmom_pkg::*;

  localparam int SRT_AW    = SLOT_W + 1;
  localparam int SRT_DEPTH = 2 ** SRT_AW;
  localparam logic [DATA_W-1:0] SIGN_MIN = {1'b1, {(DATA_W-1){1'b0}}};
  localparam logic [DATA_W-1:0] CLAMP_MIN = {1'b1, {(DATA_W-2){1'b0}}, 1'b1};

  // circular sample store and ping-pong sorted lists
  logic [DATA_W-1:0] win_mem [WINDOW];
  logic [DATA_W-1:0] srt_mem [SRT_DEPTH];

  logic [THR_W-1:0]     thr_q;
  logic [SLOT_W-1:0]    oldest_q, oldest_d;
  logic [CNT_W-1:0]     cnt_q, cnt_d;
  logic [CNT_W-1:0]     old_cnt_q;
  logic [CNT_W-1:0]     ptr_q, ptr_d;
  logic [CNT_W-1:0]     wr_q;
  logic                 ins_q, rem_q, bank_q;
  logic [DATA_W-1:0]    v_q, rm_q, cur_q;
  logic [DATA_W-1:0]    med_q, sel_q, mag_q;
  logic [DATA_W-1:0]    out_med_q;
  logic [CNT_OUT_W-1:0] out_cnt_q;
  logic                 out_flag_q;

  logic                 full;
  logic [CNT_W:0]       slot_sum;
  logic [SLOT_W-1:0]    wr_slot;
  logic                 srt_we;
  logic [DATA_W-1:0]    srt_wdata;
  logic [CNT_W-1:0]     mid_idx;
  logic [DATA_W-1:0]    sel_val, clamped;

  assign full     = (cnt_q == CNT_W'(WINDOW));
  assign slot_sum = (CNT_W+1)'(oldest_q) + (CNT_W+1)'(cnt_q);
  assign wr_slot  = full ? oldest_q :
                    (slot_sum >= (CNT_W+1)'(WINDOW)) ? SLOT_W'(slot_sum - (CNT_W+1)'(WINDOW)) :
                    SLOT_W'(slot_sum);

  always_comb begin
    oldest_d = oldest_q;
    cnt_d    = cnt_q;
    if (cmd_i.start) begin
      if (full) begin
        oldest_d = (oldest_q == SLOT_W'(WINDOW - 1)) ? '0 : oldest_q + SLOT_W'(1);
      end else begin
        cnt_d = cnt_q + CNT_W'(1);
      end
    end
  end

  always_comb begin
    if (cmd_i.start) begin
      ptr_d = '0;
    end else if (cmd_i.op == OP_DROP || cmd_i.op == OP_COPY) begin
      ptr_d = ptr_q + CNT_W'(1);
    end else begin
      ptr_d = ptr_q;
    end
  end

  assign srt_we    = (cmd_i.op == OP_INSERT) || (cmd_i.op == OP_COPY);
  assign srt_wdata = (cmd_i.op == OP_INSERT) ? v_q : cur_q;
  assign mid_idx   = cnt_q >> 1;

  assign status_o.exhausted = (ptr_q == old_cnt_q);
  assign status_o.cur_is_rm = rem_q && (cur_q == rm_q);
  assign status_o.v_before  = !ins_q && ($signed(v_q) < $signed(cur_q));
  assign status_o.ins_done  = ins_q;

  assign sel_val = (cnt_q < CNT_W'(MIN_SAMPLES)) ? '0 : med_q;
  assign clamped = (sel_val == SIGN_MIN) ? CLAMP_MIN : sel_val;

  // read of the oldest slot sees the value before this edge's write
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      win_mem[wr_slot] <= sample_i;
      rm_q             <= win_mem[oldest_q];
      v_q              <= sample_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (srt_we) begin
      srt_mem[{~bank_q, wr_q[SLOT_W-1:0]}] <= srt_wdata;
    end
    cur_q <= srt_mem[{bank_q, ptr_d[SLOT_W-1:0]}];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q     <= THR_RESET;
      oldest_q  <= '0;
      cnt_q     <= '0;
      old_cnt_q <= '0;
      ptr_q     <= '0;
      wr_q      <= '0;
      ins_q     <= 1'b0;
      rem_q     <= 1'b0;
      bank_q    <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        thr_q <= cfg_wdata_i;
      end
      oldest_q <= oldest_d;
      cnt_q    <= cnt_d;
      ptr_q    <= ptr_d;
      if (cmd_i.start) begin
        old_cnt_q <= cnt_q;
        wr_q      <= '0;
        ins_q     <= 1'b0;
        rem_q     <= full;
      end else begin
        if (srt_we) begin
          wr_q <= wr_q + CNT_W'(1);
        end
        if (cmd_i.op == OP_INSERT) begin
          ins_q <= 1'b1;
        end
        if (cmd_i.op == OP_DROP) begin
          rem_q <= 1'b0;
        end
      end
      if (cmd_i.finish) begin
        bank_q <= ~bank_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (srt_we && (wr_q == mid_idx)) begin
      med_q <= srt_wdata;
    end
    if (cmd_i.calc) begin
      sel_q <= sel_val;
      mag_q <= clamped[DATA_W-1] ? (~clamped + DATA_W'(1)) : clamped;
    end
    if (cmd_i.load) begin
      out_med_q  <= sel_q;
      out_cnt_q  <= CNT_OUT_W'(cnt_q);
      out_flag_q <= (mag_q > DATA_W'(thr_q));
    end
  end

  assign median_o      = out_med_q;
  assign count_o       = out_cnt_q;
  assign out_of_sync_o = out_flag_q;

`include "windowed_median_offset_monitor_macros.svh"

  `WMOM_ASSERT_HOLDS(a_ptr_in_list, ptr_q <= old_cnt_q)
  `WMOM_ASSERT_HOLDS(a_cnt_bound, cnt_q <= CNT_W'(WINDOW))
  `WMOM_ASSERT_IMP(a_oldest_dropped, cmd_i.finish, !rem_q)
  `WMOM_ASSERT_NXT(a_list_complete, cmd_i.finish, wr_q == cnt_q)

endmodule

@@ rtl/wmom_ctrl.sv @@
module wmom_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_tvalid_i,
  output logic                 s_tready_o,
  output logic                 m_tvalid_o,
  input  logic                 m_tready_i,
  input  wmom_pkg::dp_status_t status_i,
  output wmom_pkg::dp_cmd_t    cmd_o
);
  import wmom_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_MERGE = 4'b0010,
    ST_ABS   = 4'b0100,
    ST_OUT   = 4'b1000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_comb begin
    state_d      = state_q;
    cmd_o        = '0;
    cmd_o.op     = OP_NONE;
    s_tready_o   = 1'b0;
    out_valid_d  = out_valid_q;
    if (out_valid_q && m_tready_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      ST_IDLE: begin
        s_tready_o = 1'b1;
        if (s_tvalid_i) begin
          cmd_o.start = 1'b1;
          state_d     = ST_MERGE;
        end
      end
      ST_MERGE: begin
        if (status_i.exhausted) begin
          // new sample goes at the tail if nothing was larger
          cmd_o.op     = status_i.ins_done ? OP_NONE : OP_INSERT;
          cmd_o.finish = 1'b1;
          state_d      = ST_ABS;
        end else if (status_i.cur_is_rm) begin
          cmd_o.op = OP_DROP;
        end else if (status_i.v_before) begin
          cmd_o.op = OP_INSERT;
        end else begin
          cmd_o.op = OP_COPY;
        end
      end
      ST_ABS: begin
        cmd_o.calc = 1'b1;
        state_d    = ST_OUT;
      end
      ST_OUT: begin
        if (!out_valid_q || m_tready_i) begin
          cmd_o.load  = 1'b1;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign m_tvalid_o = out_valid_q;

endmodule

@@ bench/windowed_median_offset_monitor_test.sv @@
module windowed_median_offset_monitor_test;

  localparam longint OFFSET_MIN = {1'b1, 63'd0};
  localparam longint OFFSET_MAX = {1'b0, {63{1'b1}}};
  localparam int PHASE_ITEMS = 108;

  typedef struct {
    logic signed [63:0] median;
    logic [6:0]         count;
    logic               out_of_sync;
  } offset_result_t;

  class median_scoreboard;
    longint         samples [wmom_pkg::WINDOW];
    int             oldest;
    int             held;
    logic [31:0]    threshold;
    offset_result_t pending_results[$];
    int             errors;

    function new();
      oldest    = 0;
      held      = 0;
      threshold = wmom_pkg::THR_RESET;
      errors    = 0;
    endfunction

    function void set_threshold(input logic [31:0] value);
      threshold = value;
    endfunction

    function int pending();
      return pending_results.size();
    endfunction

    // upper median of the held samples, zero while too few are held
    function longint window_median();
      longint sorted [wmom_pkg::WINDOW];
      longint v;
      int i, j;
      if (held < wmom_pkg::MIN_SAMPLES) return 0;
      for (i = 0; i < held; i++) sorted[i] = samples[(oldest + i) % wmom_pkg::WINDOW];
      for (i = 1; i < held; i++) begin
        v = sorted[i];
        j = i;
        while (j > 0 && v < sorted[j-1]) begin
          sorted[j] = sorted[j-1];
          j--;
        end
        sorted[j] = v;
      end
      return sorted[held / 2];
    endfunction

    function void note_sample(input logic [63:0] value);
      longint         med;
      longint         clamped;
      logic [63:0]    mag;
      offset_result_t res;
      if (held >= wmom_pkg::WINDOW) begin
        samples[oldest] = value;
        oldest = (oldest + 1) % wmom_pkg::WINDOW;
      end else begin
        samples[(oldest + held) % wmom_pkg::WINDOW] = value;
        held++;
      end
      med = window_median();
      // most negative value has no positive twin
      clamped = (med == OFFSET_MIN) ? OFFSET_MIN + 1 : med;
      mag = (clamped < 0) ? -clamped : clamped;
      res.median      = med;
      res.count       = 7'(held);
      res.out_of_sync = (mag > {32'd0, threshold});
      pending_results.insert(pending_results.size(), res);
    endfunction

    function void check_result(input logic [71:0] tdata);
      offset_result_t exp_res;
      logic signed [63:0] got_median;
      logic [6:0] got_count;
      logic got_oos;
      got_median = tdata[63:0];
      got_count  = tdata[70:64];
      got_oos    = tdata[71];
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: expected no result, got median %0d count %0d flag %0b",
                 $time, got_median, got_count, got_oos);
        return;
      end
      exp_res = pending_results[0];
      pending_results.delete(0);
      if (got_median !== exp_res.median) begin
        errors++;
        $display("%0t: median expected %0d got %0d", $time, exp_res.median, got_median);
      end
      if (got_count !== exp_res.count) begin
        errors++;
        $display("%0t: count expected %0d got %0d", $time, exp_res.count, got_count);
      end
      if (got_oos !== exp_res.out_of_sync) begin
        errors++;
        $display("%0t: out_of_sync expected %0b got %0b", $time, exp_res.out_of_sync,
                 got_oos);
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        s_tvalid_i;
  logic        s_tready_o;
  logic [63:0] s_tdata_i;
  logic        m_tvalid_o;
  logic        m_tready_i;
  logic [71:0] m_tdata_o;
  logic        cfg_we_i;
  logic [31:0] cfg_wdata_i;

  median_scoreboard sb;
  bit steady;

  windowed_median_offset_monitor dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_tvalid_i  (s_tvalid_i),
    .s_tready_o  (s_tready_o),
    .s_tdata_i   (s_tdata_i),
    .m_tvalid_o  (m_tvalid_o),
    .m_tready_i  (m_tready_i),
    .m_tdata_o   (m_tdata_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always #2 clk_i = ~clk_i;

  // mostly short gaps, now and then a long one that can span a whole merge pass; none while steady
  function automatic int pick_gap();
    int roll;
    if (steady) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 70) return $urandom_range(0, 2);
    if (roll < 92) return $urandom_range(3, 15);
    return $urandom_range(40, 90);
  endfunction

  function automatic logic [63:0] pick_sample(input logic [31:0] thr, input bit lean_neg);
    int     roll;
    bit     neg;
    longint near;
    roll = $urandom_range(0, 99);
    if (roll < 55) begin
      // hover around the threshold so the flag flips back and forth
      neg  = ($urandom_range(0, 4) == 0) ? !lean_neg : lean_neg;
      near = longint'({32'd0, thr}) + $urandom_range(0, 8) - 4;
      return neg ? -near : near;
    end
    if (roll < 75) return {$urandom, $urandom};
    if (roll < 85) begin
      case ($urandom_range(0, 4))
        0: return OFFSET_MIN;
        1: return OFFSET_MAX;
        2: return 64'd0;
        3: return '1;
        default: return 64'd1;
      endcase
    end
    if (roll < 95) return longint'($urandom_range(0, 2000)) - 1000;
    if ($urandom_range(0, 1) == 0) return 64'd1 << $urandom_range(0, 63);
    return ~(64'd1 << $urandom_range(0, 63));
  endfunction

  task automatic send_sample(input logic [63:0] value);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_tvalid_i <= 1'b1;
    s_tdata_i  <= value;
    do @(posedge clk_i); while (!s_tready_o);
    sb.note_sample(value);
  endtask

  task automatic wait_idle();
    s_tvalid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  task automatic write_threshold(input logic [31:0] value);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    sb.set_threshold(value);
  endtask

  initial begin : result_sink
    int stall;
    stall = 0;
    m_tready_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && m_tvalid_o && m_tready_i) begin
        sb.check_result(m_tdata_o);
        stall = pick_gap();
      end else if (stall == 0 && $urandom_range(0, 19) == 0) begin
        stall = pick_gap();
      end
      if (stall > 0) begin
        m_tready_i <= 1'b0;
        stall--;
      end else begin
        m_tready_i <= 1'b1;
      end
    end
  end

  initial begin : watchdog
    #3000000;
    $display("Mismatches found");
    $finish;
  end

  initial begin : stimulus
    logic [63:0] directed[$];
    logic [31:0] thresholds[$];
    int p, k;
    sb = new();
    steady      = 1'b0;
    rst_ni      = 1'b0;
    s_tvalid_i  = 1'b0;
    s_tdata_i   = '0;
    cfg_we_i    = 1'b0;
    cfg_wdata_i = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // first four items report zero however large they are; then a run of the
    // most negative value drives the median there and through the clamp
    directed = '{OFFSET_MAX, OFFSET_MIN, 64'd0, '1,
                 OFFSET_MIN, OFFSET_MIN, OFFSET_MIN, OFFSET_MIN,
                 64'h258, 64'h259, 64'hFFFF_FFFF_FFFF_FDA8, 64'hFFFF_FFFF_FFFF_FDA7,
                 64'd1, 64'h0000_0000_FFFF_FFFF, 64'hFFFF_FFFF_0000_0000,
                 OFFSET_MAX, OFFSET_MAX, OFFSET_MAX, OFFSET_MAX, OFFSET_MAX,
                 OFFSET_MAX, OFFSET_MAX, '1};
    foreach (directed[i]) send_sample(directed[i]);

    thresholds = '{32'd0, 32'hFFFF_FFFF, 32'd600, 32'd1, $urandom, 32'h8000_0000};
    for (p = 0; p < thresholds.size(); p++) begin
      wait_idle();
      write_threshold(thresholds[p]);
      steady = (p == 2);
      for (k = 0; k < PHASE_ITEMS; k++) send_sample(pick_sample(thresholds[p], p[0]));
    end
    steady = 1'b0;
    wait_idle();
    repeat (80) @(posedge clk_i);

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
